>>> rtl/core/ivmn_pkg.sv
// Package: widths and helpers for the vector magnitude/normalize unit
package ivmn_pkg;
  localparam int COMP_WIDTH_DEF = 16;
  localparam int MAG_W = 17;
  localparam int NORM_W = 2;
  localparam int NUM_COMPS = 4;

  typedef struct packed {
    logic valid;
    logic stall;
  } pipe_ctl_t;
endpackage

>>> rtl/core/ivmn_sqrt.sv
// Pipelined integer square root, one result bit per stage, rounded to nearest
module ivmn_sqrt #(
  parameter int SW = 34,
  parameter int TW = 4,
  parameter int RW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [SW-1:0] in_sum,
  input  logic [TW-1:0] in_tag,
  output logic          out_vld,
  output logic [RW-1:0] out_root,
  output logic [TW-1:0] out_tag
);
  localparam int NST = (SW + 1) / 2;
  localparam int PW = 2 * NST;

  logic                 vld_r  [NST];
  logic [PW-1:0]        rem_r  [NST];
  logic [NST-1:0]       root_r [NST];
  logic [PW-1:0]        src_r  [NST-1];
  logic [TW-1:0]        tag_r  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [PW-1:0]  rem_nxt;
    logic [NST-1:0] root_nxt;
    logic [PW-1:0]  trial;
    logic [PW-1:0]  cur;
    logic [PW-1:0]  rem_in;
    logic [NST-1:0] root_in;
    logic [PW-1:0]  src_in;
    logic [TW-1:0]  tag_in;
    logic           vld_in;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign root_in = '0;
      assign src_in = PW'(in_sum);
      assign tag_in = in_tag;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign src_in = src_r[s-1];
      assign tag_in = tag_r[s-1];
      assign vld_in = vld_r[s-1];
    end
    always_comb begin
      cur = (rem_in << 2) | PW'(src_in[PW-1 -: 2]);
      trial = (PW'(root_in) << 2) | PW'(1);
      if (cur >= trial) begin
        rem_nxt = cur - trial;
        root_nxt = (root_in << 1) | NST'(1);
      end else begin
        rem_nxt = cur;
        root_nxt = root_in << 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_in;
      end
      if (adv) begin
        rem_r[s] <= rem_nxt;
        root_r[s] <= root_nxt;
        tag_r[s] <= tag_in;
      end
    end
    if (s < NST - 1) begin : g_src
      always_ff @(posedge clk) begin
        if (adv) begin
          src_r[s] <= src_in << 2;
        end
      end
    end
  end

  logic [NST:0] rnd;
  always_comb begin
    rnd = {1'b0, root_r[NST-1]} + (NST+1)'(rem_r[NST-1] > PW'(root_r[NST-1]));
    out_root = RW'(rnd);
    out_tag = tag_r[NST-1];
    out_vld = vld_r[NST-1];
  end
endmodule

>>> rtl/core/ivmn_div.sv
// Rounded quotient of a magnitude-bounded component, result in -1..1
module ivmn_div #(
  parameter int AW = 16,
  parameter int MW = 17
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [AW-1:0]     a,
  input  logic              neg,
  input  logic [MW-1:0]     mag,
  output logic [ivmn_pkg::NORM_W-1:0] q
);
  logic [MW+1:0] a2_r;
  logic [MW+1:0] m_r;
  logic          neg_r;
  logic          one;
  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r <= (MW+2)'(a) << 1;
      m_r <= (MW+2)'(mag);
      neg_r <= neg;
    end
  end
  // 2a+m >= 2m  <=>  2a >= m; a <= m so quotient <= 1
  always_comb begin
    one = (m_r != '0) && (a2_r >= m_r);
    if (!one) q = '0;
    else if (neg_r) q = '1;
    else q = ivmn_pkg::NORM_W'(1);
  end
endmodule

>>> rtl/core/int_vector4_magnitude_normalize_unit.sv
// Top level: pipelined vector magnitude and normalization
// channel | ports                         | direction
// in      | in_valid/in_ready, in_comp_*  | input transactions
// out     | out_valid/out_ready, out_*    | result transactions
// One transaction per cycle while out is not stalled; the result passes the
// abs and square registers, the one-bit-per-stage square root pipeline
// (COMP_WIDTH+1 stages) and the divide stage.
// rst_n synchronous, clears valid bits only. A stall on out freezes the
// whole pipeline; in_ready = out_ready || !out_valid.
module int_vector4_magnitude_normalize_unit #(
  parameter int COMP_WIDTH = ivmn_pkg::COMP_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COMP_WIDTH-1:0] in_comp_i,
  input  logic [COMP_WIDTH-1:0] in_comp_j,
  input  logic [COMP_WIDTH-1:0] in_comp_k,
  input  logic [COMP_WIDTH-1:0] in_comp_l,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ivmn_pkg::MAG_W-1:0]  out_magnitude,
  output logic [ivmn_pkg::NORM_W-1:0] out_norm_i,
  output logic [ivmn_pkg::NORM_W-1:0] out_norm_j,
  output logic [ivmn_pkg::NORM_W-1:0] out_norm_k,
  output logic [ivmn_pkg::NORM_W-1:0] out_norm_l
);
  localparam int AW = COMP_WIDTH;
  localparam int SQW = 2 * AW;
  localparam int SW = SQW + 2;
  localparam int RW = AW + 1;
  localparam int TW = 4 * (AW + 1);

  ivmn_pkg::pipe_ctl_t ctl;
  logic adv;
  assign adv = ctl.valid;
  always_comb begin
    ctl.stall = out_valid && !out_ready;
    ctl.valid = !ctl.stall;
  end
  assign in_ready = adv;

  logic [AW-1:0] a_r [4];
  logic [3:0]    n_r;
  logic          s1_vld_r;
  logic [AW-1:0] a_nxt [4];
  logic [3:0]    n_nxt;
  logic [AW-1:0] raw [4];
  assign raw[0] = in_comp_i;
  assign raw[1] = in_comp_j;
  assign raw[2] = in_comp_k;
  assign raw[3] = in_comp_l;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      n_nxt[c] = raw[c][AW-1];
      a_nxt[c] = n_nxt[c] ? AW'(-raw[c]) : raw[c];
    end
  end
  // abs of most negative value wraps to 2^(AW-1): kept as unsigned AW bits
  logic [SQW-1:0] sq_r [4];
  logic [TW-1:0]  t1_r;
  logic           s2_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
    if (adv) begin
      for (int c = 0; c < 4; c++) a_r[c] <= a_nxt[c];
      n_r <= n_nxt;
      for (int c = 0; c < 4; c++) sq_r[c] <= SQW'(a_r[c]) * SQW'(a_r[c]);
      t1_r <= {n_r[3], a_r[3], n_r[2], a_r[2], n_r[1], a_r[1], n_r[0], a_r[0]};
    end
  end
  logic [SW-1:0] sum;
  assign sum = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]);

  logic          sq_vld;
  logic [RW-1:0] root;
  logic [TW-1:0] t2;
  ivmn_sqrt #(.SW(SW), .TW(TW), .RW(RW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(s2_vld_r), .in_sum(sum),
    .in_tag(t1_r), .out_vld(sq_vld), .out_root(root), .out_tag(t2)
  );

  logic [RW-1:0] mag_r;
  logic          o_vld_r;
  logic [ivmn_pkg::NORM_W-1:0] q [4];
  for (genvar c = 0; c < 4; c++) begin : g_div
    ivmn_div #(.AW(AW), .MW(RW)) u_div (
      .clk(clk), .adv(adv), .a(t2[c*(AW+1) +: AW]), .neg(t2[c*(AW+1)+AW]),
      .mag(root), .q(q[c])
    );
  end
  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (adv) o_vld_r <= sq_vld;
    if (adv) mag_r <= root;
  end
  assign out_valid = o_vld_r;
  assign out_magnitude = ivmn_pkg::MAG_W'(mag_r);
  assign out_norm_i = q[0];
  assign out_norm_j = q[1];
  assign out_norm_k = q[2];
  assign out_norm_l = q[3];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("ready low while output empty");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_magnitude == '0 |-> out_norm_i == '0 && out_norm_j == '0)
    else $error("zero vector gave nonzero norm");
endmodule

>>> sim/testbench.sv
// Testbench for the vector magnitude and normalization unit
`timescale 1ns / 1ps

module testbench;
  localparam int CW = ivmn_pkg::COMP_WIDTH_DEF;
  localparam int LATENCY = CW + 4;
  localparam int N_RANDOM = 1100;
  localparam int IDLE_LIMIT = 20000;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    logic [ivmn_pkg::MAG_W-1:0]  mag;
    logic [ivmn_pkg::NORM_W-1:0] ni;
    logic [ivmn_pkg::NORM_W-1:0] nj;
    logic [ivmn_pkg::NORM_W-1:0] nk;
    logic [ivmn_pkg::NORM_W-1:0] nl;
  } norm_res_t;

  typedef struct {
    comp_t     c[ivmn_pkg::NUM_COMPS];
    logic      known;
    norm_res_t res;
  } vec_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  comp_t in_comp_i, in_comp_j, in_comp_k, in_comp_l;
  logic out_valid;
  logic out_ready;
  logic [ivmn_pkg::MAG_W-1:0]  out_magnitude;
  logic [ivmn_pkg::NORM_W-1:0] out_norm_i, out_norm_j, out_norm_k, out_norm_l;

  norm_res_t expected_results[$];
  int errors;
  int idle_cycles;
  bit hold_off_req;
  bit sending_done;

  int_vector4_magnitude_normalize_unit #(.COMP_WIDTH(CW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_comp_i(in_comp_i), .in_comp_j(in_comp_j),
    .in_comp_k(in_comp_k), .in_comp_l(in_comp_l),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_magnitude(out_magnitude),
    .out_norm_i(out_norm_i), .out_norm_j(out_norm_j),
    .out_norm_k(out_norm_k), .out_norm_l(out_norm_l)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] round_sqrt(logic [63:0] s);
    logic [63:0] rem, root, b;
    rem = s;
    root = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    if (rem > root) root = root + 1;
    return root;
  endfunction

  function automatic norm_res_t normalize_vec(comp_t c[ivmn_pkg::NUM_COMPS]);
    logic [63:0] a[ivmn_pkg::NUM_COMPS];
    logic [63:0] sum, m, q;
    logic [ivmn_pkg::NORM_W-1:0] n[ivmn_pkg::NUM_COMPS];
    norm_res_t r;
    sum = 0;
    for (int x = 0; x < ivmn_pkg::NUM_COMPS; x++) begin
      a[x] = c[x][CW-1] ? (64'd1 << CW) - {48'd0, c[x]} : {48'd0, c[x]};
      sum += a[x] * a[x];
    end
    m = round_sqrt(sum);
    for (int x = 0; x < ivmn_pkg::NUM_COMPS; x++) begin
      q = (m != 0) ? (2 * a[x] + m) / (2 * m) : 0;
      if (c[x][CW-1]) q = -q;
      n[x] = q[ivmn_pkg::NORM_W-1:0];
    end
    r.mag = m[ivmn_pkg::MAG_W-1:0];
    r.ni = n[0];
    r.nj = n[1];
    r.nk = n[2];
    r.nl = n[3];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic vec_row_t mk(int i, int j, int k, int l, bit known = 0,
                                  int m = 0, int ni = 0, int nj = 0, int nk = 0,
                                  int nl = 0);
    vec_row_t r;
    r.c[0] = comp_t'(i);
    r.c[1] = comp_t'(j);
    r.c[2] = comp_t'(k);
    r.c[3] = comp_t'(l);
    r.known = known;
    r.res = '{m[ivmn_pkg::MAG_W-1:0], ni[1:0], nj[1:0], nk[1:0], nl[1:0]};
    return r;
  endfunction

  vec_row_t directed[$];

  task automatic send_vec(vec_row_t r);
    norm_res_t p;
    p = normalize_vec(r.c);
    if (r.known && p !== r.res) report_mismatch("table row", p, r.res);
    expected_results.push_back(r.known ? r.res : p);
    in_valid <= 1'b1;
    in_comp_i <= r.c[0];
    in_comp_j <= r.c[1];
    in_comp_k <= r.c[2];
    in_comp_l <= r.c[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic comp_t rand_comp(int mode);
    case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(0, 7)) - 3;
      2: return $urandom_range(0, 1) ? comp_t'(-32768) : comp_t'(32767);
      default: return comp_t'($urandom_range(0, 300)) - 150;
    endcase
  endfunction

  // sender
  initial begin
    vec_row_t r;
    int burst, mode;
    bit held, drained;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_comp_i = '0;
    in_comp_j = '0;
    in_comp_k = '0;
    in_comp_l = '0;
    errors = 0;
    hold_off_req = 0;
    sending_done = 0;
    held = 0;
    drained = 0;
    directed.push_back(mk(0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk(1, 0, 0, 0, 1, 1, 1, 0, 0, 0));
    directed.push_back(mk(0, -1, 0, 0, 1, 1, 0, 3, 0, 0));
    directed.push_back(mk(0, 0, 32767, 0, 1, 32767, 0, 0, 1, 0));
    directed.push_back(mk(0, 0, 0, -32768, 1, 32768, 0, 0, 0, 3));
    directed.push_back(mk(-32768, -32768, -32768, -32768, 1, 65536, 3, 3, 3, 3));
    directed.push_back(mk(32767, 32767, 32767, 32767, 1, 65534, 1, 1, 1, 1));
    directed.push_back(mk(1, 1, 1, 1, 1, 2, 1, 1, 1, 1));
    directed.push_back(mk(1, 1, 0, 0));
    directed.push_back(mk(3, 4, 0, 0));
    directed.push_back(mk(-1, 1, -1, 1));
    directed.push_back(mk(32767, -32768, 1, -1));
    directed.push_back(mk(21845, -21846, 10922, -10923));
    directed.push_back(mk(2, 3, 0, 0));
    directed.push_back(mk(-5, 1, 1, 1));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[n]) send_vec(directed[n]);
    in_valid <= 1'b0;
    wait (expected_results.size() == 0);
    @(posedge clk);
    for (int n = 0; n < N_RANDOM; ) begin
      if (!held && n >= 300) begin
        held = 1;
        hold_off_req <= 1;
      end
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        mode = $urandom_range(0, 3);
        for (int x = 0; x < ivmn_pkg::NUM_COMPS; x++) r.c[x] = rand_comp(mode);
        if ($urandom_range(0, 7) == 0) r.c[$urandom_range(0, 3)] = 0;
        r.known = 0;
        send_vec(r);
      end
      if (!drained && n >= 700) begin
        drained = 1;
        in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  // receiver
  initial begin
    int pattern;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 0;
        out_ready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
      end
      pattern = $urandom_range(0, 3);
      if (pattern == 0) out_ready <= 1'b1;
      else if (pattern == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else if (pattern == 2) out_ready <= $urandom_range(0, 1);
      else out_ready <= ($urandom_range(0, 4) == 0);
    end
  end

  // result checking
  always @(posedge clk) begin
    norm_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_magnitude, 0);
      end else begin
        e = expected_results.pop_front();
        if (out_magnitude !== e.mag) report_mismatch("magnitude", out_magnitude, e.mag);
        if (out_norm_i !== e.ni) report_mismatch("norm_i", out_norm_i, e.ni);
        if (out_norm_j !== e.nj) report_mismatch("norm_j", out_norm_j, e.nj);
        if (out_norm_k !== e.nk) report_mismatch("norm_k", out_norm_k, e.nk);
        if (out_norm_l !== e.nl) report_mismatch("norm_l", out_norm_l, e.nl);
      end
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (sending_done && expected_results.size() == 0) begin
        repeat (2 * LATENCY) @(posedge clk);
        if (out_valid) report_mismatch("extra result", out_magnitude, 0);
        if (errors == 0 && expected_results.size() == 0) begin
          $display("All tests passed");
        end else begin
          $display("Some tests failed");
        end
        $finish;
      end
    end
  end
endmodule

>>> files.f
rtl/core/ivmn_pkg.sv
rtl/core/ivmn_sqrt.sv
rtl/core/ivmn_div.sv
rtl/core/int_vector4_magnitude_normalize_unit.sv
sim/testbench.sv
